>>> hw/rtl/rptc_pkg.sv
// Package for the radio panel and timer controller.
// Holds the mode and display codes, the timing thresholds and the word types.
// No dependencies.
package rptc_pkg;

  localparam int FreqW  = 11;
  localparam int TickW  = 10;
  localparam int HoldW  = 12;
  localparam int TimerW = 32;
  localparam int FlashW = 11;

  localparam logic [1:0] CM_UP   = 2'd0;
  localparam logic [1:0] CM_DOWN = 2'd1;
  localparam logic [1:0] CM_SET  = 2'd2;

  localparam logic [1:0] DS_FREQ    = 2'd0;
  localparam logic [1:0] DS_FLIGHT  = 2'd1;
  localparam logic [1:0] DS_ELAPSED = 2'd2;

  localparam logic [HoldW-1:0]  HOLD_LIMIT_MS = 12'd2000;
  localparam logic [FreqW-1:0]  CD_END_MS     = 11'd1000;
  localparam logic [FlashW-1:0] FLASH_ON_MS   = 11'd500;
  localparam logic [FlashW-1:0] FLASH_OFF_MS  = 11'd200;

  typedef struct packed {
    logic             power_on;
    logic             adf_button;
    logic             bfo_button;
    logic             swap_button;
    logic             timer_select_button;
    logic             set_reset_button;
    logic [TickW-1:0] tick_ms;
    logic             load_active;
    logic             load_standby;
    logic [FreqW-1:0] freq_value;
  } rptc_item_t;

  typedef struct packed {
    logic [FreqW-1:0]  active_khz;
    logic [TimerW-1:0] standby_display;
    logic [1:0]        display_select;
    logic [1:0]        count_state;
    logic              ant_lamp;
    logic              adf_lamp;
    logic              bfo_lamp;
    logic              frq_lamp;
    logic              flt_lamp;
    logic              et_lamp;
  } rptc_result_t;

endpackage

>>> hw/rtl/radio_panel_timer_controller_unit.sv
// Top level of the radio panel and timer controller.
// Tick update core plus an output register with a skid stage.
// Depends on rptc_pkg and rptc_core.
//
// Usage:
//   The input channel takes one word per tick: power, button levels, the
//   milliseconds since the previous tick and optional frequency loads.
//   Every accepted word produces exactly one result word on the output
//   channel: active frequency, standby display with its select code, count
//   state and the six annunciators.
//   A word accepted while the output register is free or being taken shows
//   its result on the out_ ports right after that edge. Throughput is one
//   word per cycle while out_stall is low, set by the single state stage.
//   When the receiver stalls, the result holds in the output register and
//   one further word is still accepted into the skid stage; only then does
//   in_stall rise, and it falls again as soon as the receiver takes a word.
//   Synchronous reset clears frequencies, modes, timers and the valid flags
//   of both output stages; no result is pending after reset.
module radio_panel_timer_controller_unit
  import rptc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_power_on,
  input  logic              in_adf_button,
  input  logic              in_bfo_button,
  input  logic              in_swap_button,
  input  logic              in_timer_select_button,
  input  logic              in_set_reset_button,
  input  logic [TickW-1:0]  in_tick_ms,
  input  logic              in_load_active,
  input  logic              in_load_standby,
  input  logic [FreqW-1:0]  in_freq_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [FreqW-1:0]  out_active_khz,
  output logic [TimerW-1:0] out_standby_display,
  output logic [1:0]        out_display_select,
  output logic [1:0]        out_count_state,
  output logic              out_ant_lamp,
  output logic              out_adf_lamp,
  output logic              out_bfo_lamp,
  output logic              out_frq_lamp,
  output logic              out_flt_lamp,
  output logic              out_et_lamp
);

  rptc_item_t   item;
  rptc_result_t result;
  rptc_result_t out_r;
  rptc_result_t skid_r;
  logic         out_valid_r;
  logic         skid_valid_r;
  logic         accept;
  logic         take;

  assign item.power_on            = in_power_on;
  assign item.adf_button          = in_adf_button;
  assign item.bfo_button          = in_bfo_button;
  assign item.swap_button         = in_swap_button;
  assign item.timer_select_button = in_timer_select_button;
  assign item.set_reset_button    = in_set_reset_button;
  assign item.tick_ms             = in_tick_ms;
  assign item.load_active         = in_load_active;
  assign item.load_standby        = in_load_standby;
  assign item.freq_value          = in_freq_value;

  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !skid_valid_r;
  assign take     = out_valid_r && !out_stall;

  rptc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (accept),
    .item   (item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_r || take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) begin
        out_r <= skid_r;
      end
    end else if (accept) begin
      if (!out_valid_r || take) begin
        out_r <= result;
      end else begin
        skid_r <= result;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_active_khz      = out_r.active_khz;
  assign out_standby_display = out_r.standby_display;
  assign out_display_select  = out_r.display_select;
  assign out_count_state     = out_r.count_state;
  assign out_ant_lamp        = out_r.ant_lamp;
  assign out_adf_lamp        = out_r.adf_lamp;
  assign out_bfo_lamp        = out_r.bfo_lamp;
  assign out_frq_lamp        = out_r.frq_lamp;
  assign out_flt_lamp        = out_r.flt_lamp;
  assign out_et_lamp         = out_r.et_lamp;

  // A word can only wait in the skid stage behind a word in the output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds a word while the output register is empty");

  // The count state never takes the unused code.
  a_count_state_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_count_state <= CM_SET))
    else $error("count state shows an unused code");

  // The FLT lamp is only lit while the flight timer is on the display.
  a_flt_matches_display: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_flt_lamp) |-> (out_display_select == DS_FLIGHT))
    else $error("FLT lamp lit while flight timer is not shown");

  // ANT and ADF annunciators are never lit together.
  a_ant_adf_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_ant_lamp && out_adf_lamp))
    else $error("ANT and ADF lamps lit together");

  // A word that enters the skid stage is moved to the output once taken.
  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_stall) |=> (out_valid_r && !skid_valid_r))
    else $error("skid stage did not drain after the output was taken");

endmodule

>>> hw/rtl/rptc_core.sv
// Panel state and tick update of the radio panel and timer controller.
// Holds frequencies, modes, button history and timers; updates them once per word.
// Depends on rptc_pkg.
module rptc_core
  import rptc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  rptc_item_t   item,
  output rptc_result_t result
);

  logic [FreqW-1:0]  active_r, active_nxt;
  logic [FreqW-1:0]  standby_r, standby_nxt;
  logic              show_r, show_nxt;
  logic              esel_r, esel_nxt;
  logic [1:0]        cm_r, cm_nxt;
  logic              pswap_r, pswap_nxt;
  logic              ptsel_r, ptsel_nxt;
  logic              psrst_r, psrst_nxt;
  logic [HoldW-1:0]  hold_r, hold_nxt;
  logic [TimerW-1:0] flight_r, flight_nxt;
  logic [TimerW-1:0] elapsed_r, elapsed_nxt;
  logic [FlashW-1:0] flash_r, flash_nxt;
  logic              et_r, et_nxt;

  logic [HoldW:0]    hold_sum;
  logic [TimerW:0]   flight_sum;
  logic [TimerW:0]   elapsed_sum;
  logic [FlashW:0]   flash_sum;
  logic [FreqW-1:0]  cd_limit;
  logic [FreqW-1:0]  swap_tmp;

  always_comb begin
    active_nxt  = active_r;
    standby_nxt = standby_r;
    show_nxt    = show_r;
    esel_nxt    = esel_r;
    cm_nxt      = cm_r;
    pswap_nxt   = pswap_r;
    ptsel_nxt   = ptsel_r;
    psrst_nxt   = psrst_r;
    hold_nxt    = hold_r;
    flight_nxt  = flight_r;
    elapsed_nxt = elapsed_r;
    flash_nxt   = flash_r;
    et_nxt      = et_r;
    hold_sum    = '0;
    flight_sum  = '0;
    elapsed_sum = '0;
    flash_sum   = '0;
    cd_limit    = '0;
    swap_tmp    = '0;

    if (item.load_active) begin
      active_nxt = item.freq_value;
    end
    if (item.load_standby) begin
      standby_nxt = item.freq_value;
    end

    if (item.power_on) begin
      if (item.swap_button && !pswap_r && !show_nxt) begin
        swap_tmp    = active_nxt;
        active_nxt  = standby_nxt;
        standby_nxt = swap_tmp;
      end else if (item.swap_button) begin
        show_nxt = 1'b0;
        cm_nxt   = CM_UP;
      end
      pswap_nxt = item.swap_button;

      if (item.timer_select_button && !ptsel_r) begin
        esel_nxt = show_nxt ? !esel_nxt : 1'b0;
        show_nxt = 1'b1;
      end
      ptsel_nxt = item.timer_select_button;

      if (item.set_reset_button && !psrst_r) begin
        hold_nxt = '0;
      end
      if (item.set_reset_button && psrst_r) begin
        hold_sum = {1'b0, hold_r} + {{(HoldW + 1 - TickW){1'b0}}, item.tick_ms};
        hold_nxt = hold_sum[HoldW] ? {HoldW{1'b1}} : hold_sum[HoldW-1:0];
        if (hold_nxt > HOLD_LIMIT_MS) begin
          esel_nxt    = 1'b1;
          cm_nxt      = CM_SET;
          elapsed_nxt = '0;
        end
      end
      if (!item.set_reset_button && psrst_r) begin
        if (hold_nxt > HOLD_LIMIT_MS) begin
          cm_nxt = cm_nxt;
        end else if (cm_nxt == CM_SET) begin
          cm_nxt = CM_DOWN;
        end else begin
          cm_nxt      = CM_UP;
          elapsed_nxt = '0;
        end
      end
      psrst_nxt = item.set_reset_button;

      flight_sum = {1'b0, flight_r} + {{(TimerW + 1 - TickW){1'b0}}, item.tick_ms};
      flight_nxt = flight_sum[TimerW] ? {TimerW{1'b1}} : flight_sum[TimerW-1:0];

      if (!item.set_reset_button) begin
        if (cm_nxt == CM_UP) begin
          elapsed_sum = {1'b0, elapsed_nxt} +
                        {{(TimerW + 1 - TickW){1'b0}}, item.tick_ms};
          elapsed_nxt = elapsed_sum[TimerW] ? {TimerW{1'b1}} : elapsed_sum[TimerW-1:0];
        end else if (cm_nxt == CM_DOWN) begin
          cd_limit = {1'b0, item.tick_ms} + CD_END_MS;
          if (elapsed_nxt < {{(TimerW - FreqW){1'b0}}, cd_limit}) begin
            cm_nxt      = CM_UP;
            elapsed_nxt = '0;
          end else begin
            elapsed_nxt = elapsed_nxt - {{(TimerW - TickW){1'b0}}, item.tick_ms};
          end
        end
      end

      if (cm_nxt < CM_SET) begin
        et_nxt = show_nxt && esel_nxt;
      end else begin
        flash_sum = {1'b0, flash_r} + {{(FlashW + 1 - TickW){1'b0}}, item.tick_ms};
        flash_nxt = flash_sum[FlashW] ? {FlashW{1'b1}} : flash_sum[FlashW-1:0];
        if (et_r && flash_nxt > FLASH_ON_MS) begin
          et_nxt    = 1'b0;
          flash_nxt = flash_nxt - FLASH_ON_MS;
        end else if (!et_r && flash_nxt > FLASH_OFF_MS) begin
          et_nxt    = 1'b1;
          flash_nxt = flash_nxt - FLASH_OFF_MS;
        end
      end
    end else begin
      flight_nxt  = '0;
      elapsed_nxt = '0;
      et_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= '0;
      standby_r <= '0;
      show_r    <= 1'b0;
      esel_r    <= 1'b0;
      cm_r      <= CM_UP;
      pswap_r   <= 1'b0;
      ptsel_r   <= 1'b0;
      psrst_r   <= 1'b0;
      hold_r    <= '0;
      flight_r  <= '0;
      elapsed_r <= '0;
      flash_r   <= '0;
      et_r      <= 1'b0;
    end else if (en) begin
      active_r  <= active_nxt;
      standby_r <= standby_nxt;
      show_r    <= show_nxt;
      esel_r    <= esel_nxt;
      cm_r      <= cm_nxt;
      pswap_r   <= pswap_nxt;
      ptsel_r   <= ptsel_nxt;
      psrst_r   <= psrst_nxt;
      hold_r    <= hold_nxt;
      flight_r  <= flight_nxt;
      elapsed_r <= elapsed_nxt;
      flash_r   <= flash_nxt;
      et_r      <= et_nxt;
    end
  end

  always_comb begin
    result.active_khz  = active_nxt;
    result.count_state = cm_nxt;
    if (!show_nxt) begin
      result.display_select  = DS_FREQ;
      result.standby_display = {{(TimerW - FreqW){1'b0}}, standby_nxt};
    end else if (!esel_nxt) begin
      result.display_select  = DS_FLIGHT;
      result.standby_display = flight_nxt;
    end else begin
      result.display_select  = DS_ELAPSED;
      result.standby_display = elapsed_nxt;
    end
    result.ant_lamp = item.power_on && item.adf_button;
    result.adf_lamp = item.power_on && !item.adf_button;
    result.bfo_lamp = item.power_on && item.bfo_button;
    result.frq_lamp = item.power_on && !show_nxt;
    result.flt_lamp = item.power_on && show_nxt && !esel_nxt;
    result.et_lamp  = et_nxt;
  end

endmodule
